// File: hdl/tspr_pkg.sv
// Shared types and constants for the transport stream PTS/DTS restamper.
// Used by tspr_front, tspr_queue, tspr_back and ts_pes_timestamp_rewriter.
package tspr_pkg;

    // Nominal transport packet length in bytes
    localparam int unsigned PKT_BYTES = 188;
    localparam logic [9:0]  PKT_LIMIT = 10'(PKT_BYTES);

    // Byte positions inside a packet
    localparam logic [7:0] POS_PID_HI = 8'd1;
    localparam logic [7:0] POS_PID_LO = 8'd2;
    localparam logic [7:0] POS_AFC    = 8'd3;
    localparam logic [7:0] POS_AF_LEN = 8'd4;
    localparam logic [7:0] POS_MAX    = 8'hFF;

    // PES header layout, relative to the start of the PES header
    localparam logic [9:0] PES_FLAGS_OFS = 10'd7;
    localparam logic [9:0] PES_STAMP_OFS = 10'd9;
    localparam logic [9:0] PTS_ONLY_LEN  = 10'd5;
    localparam logic [9:0] PTS_DTS_LEN   = 10'd10;
    localparam logic [9:0] PTS_NEED      = 10'd14;
    localparam logic [9:0] PTS_DTS_NEED  = 10'd19;
    localparam logic [7:0] PES_NO_AF     = 8'd4;
    localparam logic [8:0] PES_AF_BASE   = 9'd5;

    // Null PID forcing masks
    localparam logic [12:0] NULL_PID    = 13'h1FFF;
    localparam logic [7:0]  PID_HI_MASK = 8'h1F;
    localparam logic [7:0]  PID_LO_MASK = 8'hFF;

    // Timestamp limits
    localparam logic [32:0] STAMP_MAX        = 33'h1_FFFF_FFFF;
    localparam logic [32:0] STAMP_OFFSET_RST = 33'd972000000;
    localparam logic [2:0]  STAMP_BYTES      = 3'd5;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_STAMP_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKING_ON  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKED_PID  = 2'd2;

    // Command queue depth
    localparam int unsigned QDEPTH  = 4;
    localparam int unsigned QPTR_W  = $clog2(QDEPTH);
    localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

    // One queued command: up to five bytes, sent most significant byte first
    typedef struct packed {
        logic [39:0] data;
        logic [2:0]  count;
        logic        first;
        logic        restamp;
    } tspr_cmd_t;

endpackage

// File: hdl/tspr_front.sv
// Front end: accepts stream bytes, tracks packet position and PES header,
// and pushes output commands to the queue. Depends on tspr_pkg.
module tspr_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,     // [7:0] in_byte
    input  logic               s_tuser,     // [0] in_first
    input  logic               blocking_on,
    input  logic [12:0]        blocked_pid,
    input  logic               q_full,
    output logic               q_push,
    output tspr_pkg::tspr_cmd_t q_cmd
);
    import tspr_pkg::*;

    logic [7:0]  pos_reg, pos_next;
    logic        us_reg, us_next;
    logic        ap_reg, ap_next;
    logic [7:0]  pb_reg, pb_next;
    logic [1:0]  sf_reg, sf_next;
    logic [39:0] held_reg, held_next;
    logic [2:0]  hc_reg, hc_next;

    logic accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // Parse the byte and build the command
    always_comb
    begin
        logic [7:0]  pos;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [12:0] pid;
        logic [8:0]  base;
        logic [9:0]  pb_w;
        logic [9:0]  pos_w;
        logic [9:0]  len;
        logic [9:0]  need;
        logic [1:0]  fl;
        logic [2:0]  hc_inc;

        pos       = s_tuser ? '0 : pos_reg;
        pos_w     = {2'b00, pos};
        b1        = held_reg[7:0];
        b2        = s_tdata;
        pid       = {b1[4:0], b2};
        base      = PES_AF_BASE + {1'b0, s_tdata};
        pb_w      = '0;
        len       = sf_reg[0] ? PTS_DTS_LEN : PTS_ONLY_LEN;
        fl        = s_tdata[7:6];
        need      = '0;
        hc_inc    = hc_reg + 3'd1;
        pos_next  = pos_reg;
        us_next   = us_reg;
        ap_next   = ap_reg;
        pb_next   = pb_reg;
        sf_next   = sf_reg;
        held_next = held_reg;
        hc_next   = hc_reg;
        q_push    = 1'b0;
        q_cmd     = '0;

        if (accept)
        begin
            if (s_tuser)
            begin
                // Flush held bytes, then the sync byte
                q_push        = 1'b1;
                q_cmd.data    = {held_reg[31:0], s_tdata};
                q_cmd.count   = hc_inc;
                q_cmd.first   = 1'b1;
                us_next       = 1'b0;
                ap_next       = 1'b0;
                pb_next       = '0;
                sf_next       = '0;
                hc_next       = '0;
            end
            else if (pos == POS_PID_HI)
            begin
                // Hold the first PID byte
                held_next = {32'd0, s_tdata};
                hc_next   = 3'd1;
                us_next   = s_tdata[6];
            end
            else if (pos == POS_PID_LO && hc_reg == 3'd1)
            begin
                // Release both PID bytes, nulled when blocked
                if (blocking_on && pid == blocked_pid)
                begin
                    b1 = b1 | PID_HI_MASK;
                    b2 = b2 | PID_LO_MASK;
                end
                hc_next     = '0;
                q_push      = 1'b1;
                q_cmd.data  = {24'd0, b1, b2};
                q_cmd.count = 3'd2;
            end
            else
            begin
                // Locate the PES header
                if (pos == POS_AFC)
                begin
                    ap_next = s_tdata[5];
                    if (!s_tdata[5])
                        pb_next = PES_NO_AF;
                end
                else if (pos == POS_AF_LEN && ap_reg)
                begin
                    pb_next = base[8] ? POS_MAX : base[7:0];
                end
                pb_w = {2'b00, pb_next};

                if (us_reg && pb_next != '0 && pos_w == pb_w + PES_FLAGS_OFS &&
                    pos_w < PKT_LIMIT)
                begin
                    // Take the PTS/DTS flags if the stamps fit in the packet
                    if (fl[1])
                        need = fl[0] ? PTS_DTS_NEED : PTS_NEED;
                    if (fl[1] && pb_w + need <= PKT_LIMIT)
                        sf_next = fl;
                    else
                        sf_next = '0;
                    q_push      = 1'b1;
                    q_cmd.data  = {32'd0, s_tdata};
                    q_cmd.count = 3'd1;
                end
                else if (sf_reg[1] && pb_next != '0 && pos_w >= pb_w + PES_STAMP_OFS &&
                         pos_w < pb_w + PES_STAMP_OFS + len)
                begin
                    // Hold timestamp bytes, release five at a time for restamping
                    held_next = {held_reg[31:0], s_tdata};
                    hc_next   = hc_inc;
                    if (hc_inc >= STAMP_BYTES)
                    begin
                        q_push        = 1'b1;
                        q_cmd.data    = {held_reg[31:0], s_tdata};
                        q_cmd.count   = STAMP_BYTES;
                        q_cmd.restamp = 1'b1;
                        hc_next       = '0;
                    end
                end
                else
                begin
                    q_push      = 1'b1;
                    q_cmd.data  = {32'd0, s_tdata};
                    q_cmd.count = 3'd1;
                end
            end
            pos_next = (pos == POS_MAX) ? POS_MAX : pos + 8'd1;
        end
    end

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            us_reg  <= 1'b0;
            ap_reg  <= 1'b0;
            pb_reg  <= '0;
            sf_reg  <= '0;
            hc_reg  <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            us_reg  <= us_next;
            ap_reg  <= ap_next;
            pb_reg  <= pb_next;
            sf_reg  <= sf_next;
            hc_reg  <= hc_next;
        end
    end

    // Held bytes carry no reset
    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

endmodule

// File: hdl/tspr_queue.sv
// Short command queue between front end and back end.
// Depends on tspr_pkg.
module tspr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tspr_pkg::tspr_cmd_t push_cmd,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output tspr_pkg::tspr_cmd_t head
);
    import tspr_pkg::*;

    tspr_cmd_t         mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Write storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_cmd;
    end

endmodule

// File: hdl/tspr_back.sv
// Back end: takes queued commands, restamps PTS/DTS groups and sends
// bytes one per cycle, while the receiver is ready, through an output register. Depends on tspr_pkg.
module tspr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [32:0]         stamp_offset,
    input  logic                q_empty,
    input  tspr_pkg::tspr_cmd_t q_head,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,    // [7:0] out_byte
    output logic                m_tuser,    // [0] out_first
    output logic                m_tlast
);
    import tspr_pkg::*;

    logic        work_valid_reg, work_valid_next;
    logic [39:0] work_data_reg, work_data_next;
    logic [2:0]  work_left_reg, work_left_next;
    logic        work_first_reg, work_first_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_first_reg, out_first_next;
    logic        out_last_reg, out_last_next;

    logic        load_out;
    logic        work_done;
    logic [7:0]  cur_byte;

    // Decode a held 5-byte stamp, add the offset with saturation, repack
    function automatic logic [39:0] restamp_bytes(input logic [39:0] raw,
                                                  input logic [32:0] off);
        logic [32:0] t;
        logic [33:0] sum;
        logic [32:0] ts;
        logic [7:0]  r0;
        logic [7:0]  r2;
        logic [7:0]  r4;
        t   = {raw[35:33], raw[31:17], raw[15:1]};
        sum = {1'b0, t} + {1'b0, off};
        ts  = sum[33] ? STAMP_MAX : sum[32:0];
        r0  = {raw[39:36], ts[32:30], raw[32]};
        r2  = {ts[21:15], raw[16]};
        r4  = {ts[6:0], raw[0]};
        return {r0, ts[29:22], r2, ts[14:7], r4};
    endfunction

    // Select the next byte to send, most significant first
    always_comb
    begin
        case (work_left_reg)
            3'd5:    cur_byte = work_data_reg[39:32];
            3'd4:    cur_byte = work_data_reg[31:24];
            3'd3:    cur_byte = work_data_reg[23:16];
            3'd2:    cur_byte = work_data_reg[15:8];
            default: cur_byte = work_data_reg[7:0];
        endcase
    end

    assign load_out  = work_valid_reg && (!out_valid_reg || m_tready);
    assign work_done = load_out && (work_left_reg == 3'd1);
    assign q_pop     = !q_empty && (!work_valid_reg || work_done);

    // Step the work register and the output register
    always_comb
    begin
        work_valid_next = work_valid_reg;
        work_data_next  = work_data_reg;
        work_left_next  = work_left_reg;
        work_first_next = work_first_reg;
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        out_first_next  = out_first_reg;
        out_last_next   = out_last_reg;

        if (load_out)
        begin
            out_valid_next  = 1'b1;
            out_byte_next   = cur_byte;
            out_last_next   = (work_left_reg == 3'd1);
            out_first_next  = (work_left_reg == 3'd1) && work_first_reg;
            work_left_next  = work_left_reg - 3'd1;
            work_valid_next = (work_left_reg != 3'd1);
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (q_pop)
        begin
            work_valid_next = 1'b1;
            work_data_next  = q_head.restamp ? restamp_bytes(q_head.data, stamp_offset)
                                             : q_head.data;
            work_left_next  = q_head.count;
            work_first_next = q_head.first;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            work_left_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            work_valid_reg <= work_valid_next;
            work_left_reg  <= work_left_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        work_data_reg  <= work_data_next;
        work_first_reg <= work_first_next;
        out_byte_reg   <= out_byte_next;
        out_first_reg  <= out_first_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_first_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: hdl/ts_pes_timestamp_rewriter.sv
// Top level of the transport stream PTS/DTS restamper with PID nulling.
// Depends on tspr_pkg, tspr_front, tspr_queue and tspr_back.
//
//  channel   direction  ports                               payload
//  s         in         s_tvalid s_tready s_tdata s_tuser   in_byte, in_first
//  m         out        m_tvalid m_tready m_tdata m_tuser   out_byte, out_first,
//                       m_tlast                             out_last
//  cfg       in         cfg_we cfg_index cfg_data           0 stamp_offset,
//                                                           1 blocking_on, 2 blocked_pid
//
// One byte is accepted per cycle while the four-entry command queue has room.
// The back end sends one byte per cycle while the receiver is ready; a
// restamped group of five bytes or a packet start after held bytes occupies
// it until all its bytes are sent, so input stalls only when such bursts or
// a stalled receiver fill the queue.
// Reset is asynchronous, active low, and needs no clearing pass.
module ts_pes_timestamp_rewriter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tuser,    // [0] in_first
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tuser,    // [0] out_first
    output logic        m_tlast,    // out_last
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [32:0] cfg_data
);
    import tspr_pkg::*;

    logic [32:0] stamp_offset_reg;
    logic        blocking_on_reg;
    logic [12:0] blocked_pid_reg;

    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;
    tspr_cmd_t   q_cmd;
    tspr_cmd_t   q_head;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stamp_offset_reg <= STAMP_OFFSET_RST;
            blocking_on_reg  <= 1'b0;
            blocked_pid_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STAMP_OFFSET: stamp_offset_reg <= cfg_data;
                CFG_BLOCKING_ON:  blocking_on_reg  <= cfg_data[0];
                CFG_BLOCKED_PID:  blocked_pid_reg  <= cfg_data[12:0];
                default:          ;
            endcase
        end
    end

    tspr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .blocking_on (blocking_on_reg),
        .blocked_pid (blocked_pid_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_cmd)
    );

    tspr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    tspr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .stamp_offset (stamp_offset_reg),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

    // A packet start byte always closes the results of its item
    a_first_is_last : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("sync byte sent without last mark");

    // Never push into a full queue
    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command queue overflow");

    // Never pop from an empty queue
    a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("command queue underflow");

endmodule

// File: sim/ts_pes_timestamp_rewriter_test.sv
// Self-checking testbench for ts_pes_timestamp_rewriter: PTS/DTS restamping and PID nulling.
// Drives transport stream items under random idling and checks every output item against a
// built-in predictor. Depends on tspr_pkg and the ts_pes_timestamp_rewriter RTL.
`timescale 1ns / 100ps

module ts_pes_timestamp_rewriter_test;
    import tspr_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int REPORT_MAX   = 10;

    // One output item as predicted
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
    } ts_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] in_byte
    logic        s_tuser = 1'b0;    // [0] in_first
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // [7:0] out_byte
    logic        m_tuser;           // [0] out_first
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_STAMP_OFFSET;
    logic [32:0] cfg_data = '0;

    // Shadow of the configuration registers
    logic [32:0] cur_offset = STAMP_OFFSET_RST;
    logic        cur_block_on = 1'b0;
    logic [12:0] cur_blocked_pid = '0;

    // Predictor state
    int unsigned byte_pos = 0;
    logic        unit_start = 1'b0;
    logic        adapt_on = 1'b0;
    int unsigned pes_base = 0;
    logic [1:0]  stamp_flags = 2'b00;
    logic [39:0] held = '0;
    int unsigned held_cnt = 0;

    ts_byte_t    step_out[$];
    ts_byte_t    expected_out[$];
    logic [7:0]  pkt_buf[$];

    int          accepted_count = 0;
    int          mismatches = 0;
    int          cycle_count = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        hold_go = 1'b0;
    int          hold_left = 0;

    ts_pes_timestamp_rewriter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Output side: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_go)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        if (!rst_n || hold_go || hold_left > 1)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Compare each output item with the oldest prediction
    always @(posedge clk)
    begin
        ts_byte_t exp_item;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_out.size() == 0)
            begin
                if (mismatches < REPORT_MAX)
                    $display("%0t: unexpected item data=%02h first=%0b last=%0b",
                             $realtime, m_tdata, m_tuser, m_tlast);
                mismatches <= mismatches + 1;
            end
            else
            begin
                exp_item = expected_out.pop_front();
                if (m_tdata !== exp_item.data || m_tuser !== exp_item.first ||
                    m_tlast !== exp_item.last)
                begin
                    if (mismatches < REPORT_MAX)
                        $display("%0t: mismatch exp %02h %0b %0b, got %02h %0b %0b",
                                 $realtime, exp_item.data, exp_item.first, exp_item.last,
                                 m_tdata, m_tuser, m_tlast);
                    mismatches <= mismatches + 1;
                end
            end
        end
    end

    function automatic void emit_byte(input logic [7:0] b, input logic f);
        step_out.push_back('{data: b, first: f, last: 1'b0});
    endfunction

    // Release held bytes unchanged, oldest first
    function automatic void flush_held();
        for (int i = 0; i < held_cnt && i < STAMP_BYTES; i++)
            emit_byte(8'(held >> (8 * (held_cnt - 1 - i))), 1'b0);
        held_cnt = 0;
    endfunction

    // Decode the held timestamp, add the offset with saturation and repack it
    function automatic void restamp_held();
        logic [7:0]  b [5];
        logic [33:0] sum;
        logic [32:0] ts;
        for (int i = 0; i < 5; i++)
            b[i] = 8'(held >> (8 * (4 - i)));
        sum = {1'b0, held[35:33], held[31:17], held[15:1]} + {1'b0, cur_offset};
        ts = (sum > {1'b0, STAMP_MAX}) ? STAMP_MAX : sum[32:0];
        b[0] = (b[0] & 8'hF1) | {4'b0000, ts[32:30], 1'b0};
        b[1] = ts[29:22];
        b[2] = {ts[21:15], b[2][0]};
        b[3] = ts[14:7];
        b[4] = {ts[6:0], b[4][0]};
        for (int i = 0; i < 5; i++)
            emit_byte(b[i], 1'b0);
        held_cnt = 0;
    endfunction

    // Work out the output items that one accepted input item causes
    function automatic void predict_rewrite(input logic [7:0] b, input logic f);
        int unsigned pos;
        int unsigned span;
        int unsigned need;
        logic [1:0]  fl;
        logic [7:0]  pid_hi;
        logic [7:0]  pid_lo;
        step_out.delete();
        if (f)
        begin
            flush_held();
            pos = 0;
            unit_start = 1'b0;
            adapt_on = 1'b0;
            pes_base = 0;
            stamp_flags = 2'b00;
        end
        else
            pos = byte_pos;

        if (pos == POS_PID_HI)
        begin
            held = {32'h0, b};
            held_cnt = 1;
            unit_start = b[6];
        end
        else if (pos == POS_PID_LO && held_cnt == 1)
        begin
            pid_hi = held[7:0];
            pid_lo = b;
            if (cur_block_on && {pid_hi[4:0], pid_lo} == cur_blocked_pid)
            begin
                pid_hi = pid_hi | PID_HI_MASK;
                pid_lo = pid_lo | PID_LO_MASK;
            end
            held_cnt = 0;
            emit_byte(pid_hi, 1'b0);
            emit_byte(pid_lo, 1'b0);
        end
        else
        begin
            span = stamp_flags[0] ? PTS_DTS_LEN : PTS_ONLY_LEN;
            if (pos == POS_AFC)
            begin
                adapt_on = b[5];
                if (!adapt_on)
                    pes_base = PES_NO_AF;
            end
            else if (pos == POS_AF_LEN && adapt_on)
                pes_base = (PES_AF_BASE + b > POS_MAX) ? POS_MAX : PES_AF_BASE + b;

            if (unit_start && pes_base != 0 && pos == pes_base + PES_FLAGS_OFS &&
                pos < PKT_BYTES)
            begin
                fl = b[7:6];
                need = fl[1] ? (fl[0] ? PTS_DTS_NEED : PTS_NEED) : 0;
                stamp_flags = (need != 0 && pes_base + need <= PKT_BYTES) ? fl : 2'b00;
                emit_byte(b, f);
            end
            else if (stamp_flags[1] && pes_base != 0 && pos >= pes_base + PES_STAMP_OFS &&
                     pos < pes_base + PES_STAMP_OFS + span)
            begin
                held = {held[31:0], b};
                held_cnt++;
                if (held_cnt >= STAMP_BYTES)
                    restamp_held();
            end
            else
                emit_byte(b, f);
        end

        byte_pos = (pos >= POS_MAX) ? POS_MAX : pos + 1;
        if (step_out.size() != 0)
            step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[i])
            expected_out.push_back(step_out[i]);
    endfunction

    // Offer one item, idling at random first, and predict once it is taken
    task automatic send_item(input logic [7:0] b, input logic f);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= f;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_rewrite(b, f);
        accepted_count++;
    endtask

    task automatic send_packet(input logic with_first);
        foreach (pkt_buf[i])
            send_item(pkt_buf[i], with_first && i == 0);
    endtask

    // Drop valid, wait for every prediction to arrive, then let the pipe settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [32:0] offset, input logic block_on,
                              input logic [12:0] pid);
        cfg_we <= 1'b1;
        cfg_index <= CFG_STAMP_OFFSET;
        cfg_data <= offset;
        @(posedge clk);
        cfg_index <= CFG_BLOCKING_ON;
        cfg_data <= 33'(block_on);
        @(posedge clk);
        cfg_index <= CFG_BLOCKED_PID;
        cfg_data <= 33'(pid);
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_offset = offset;
        cur_block_on = block_on;
        cur_blocked_pid = pid;
    endtask

    function automatic logic [39:0] pack_stamp(input logic [3:0] prefix, input logic [32:0] ts);
        return {prefix, ts[32:30], 1'b1, ts[29:22], ts[21:15], 1'b1, ts[14:7], ts[6:0], 1'b1};
    endfunction

    function automatic logic [32:0] random_stamp();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return STAMP_MAX;
        else if (pick < 20)
            return '0;
        return {1'($urandom_range(1, 0)), 32'($urandom())};
    endfunction

    // Assemble a packet with an optional adaptation field and PES header, cut to len
    task automatic build_packet(input int len, input logic pusi, input logic [12:0] pid,
                                input logic af_on, input int af_len, input logic [1:0] flags,
                                input logic [32:0] pts, input logic [32:0] dts,
                                input logic clean);
        logic [39:0] st;
        pkt_buf.delete();
        pkt_buf.push_back(8'h47);
        pkt_buf.push_back({1'($urandom_range(1, 0)), pusi, 1'($urandom_range(1, 0)), pid[12:8]});
        pkt_buf.push_back(pid[7:0]);
        pkt_buf.push_back({2'($urandom_range(3, 0)), af_on, 1'b1, 4'($urandom_range(15, 0))});
        if (af_on)
        begin
            pkt_buf.push_back(8'(af_len));
            repeat (af_len) pkt_buf.push_back(8'($urandom_range(255, 0)));
        end
        pkt_buf.push_back(8'h00);
        pkt_buf.push_back(8'h00);
        pkt_buf.push_back(8'h01);
        pkt_buf.push_back(8'hE0);
        pkt_buf.push_back(8'($urandom_range(255, 0)));
        pkt_buf.push_back(8'($urandom_range(255, 0)));
        pkt_buf.push_back({2'b10, 6'($urandom_range(63, 0))});
        pkt_buf.push_back({flags, 6'($urandom_range(63, 0))});
        pkt_buf.push_back(flags[0] ? 8'd10 : 8'd5);
        for (int k = 0; k < 2; k++)
        begin
            if ((k == 0 && flags[1]) || (k == 1 && flags[0]))
            begin
                st = (k == 0) ? pack_stamp(flags[0] ? 4'b0011 : 4'b0010, pts)
                              : pack_stamp(4'b0001, dts);
                // Corrupt prefix and marker bits now and then
                if (!clean)
                    st = st ^ (40'({$urandom(), $urandom()}) & 40'hF1_0001_0001);
                for (int i = 4; i >= 0; i--)
                    pkt_buf.push_back(st[8 * i +: 8]);
            end
        end
        while (pkt_buf.size() < len)
            pkt_buf.push_back(8'($urandom_range(255, 0)));
        while (pkt_buf.size() > len)
            void'(pkt_buf.pop_back());
    endtask

    task automatic send_random_packet();
        int          af_len;
        int          base;
        int          len;
        int          pick;
        logic        af_on;
        logic [1:0]  flags;
        logic [12:0] pid;
        af_on = ($urandom_range(99) < 30);
        af_len = $urandom_range(10, 0);
        base = af_on ? PES_AF_BASE + af_len : PES_NO_AF;
        pick = $urandom_range(99);
        flags = (pick < 45) ? 2'b10 : (pick < 80) ? 2'b11 : (pick < 90) ? 2'b01 : 2'b00;
        pick = $urandom_range(99);
        pid = (pick < 40) ? cur_blocked_pid : (pick < 60) ? NULL_PID :
              (pick < 75) ? 13'h0000 : 13'($urandom_range(8191, 0));
        // Mostly whole headers; some packets cut short before the header ends
        if ($urandom_range(99) < 85)
            len = base + PTS_DTS_NEED + $urandom_range(4, 0);
        else
            len = $urandom_range(base + PTS_DTS_NEED - 1, 4);
        build_packet(len, $urandom_range(99) < 85, pid, af_on, af_len, flags,
                     random_stamp(), random_stamp(), $urandom_range(99) >= 10);
        send_packet(1'b1);
    endtask

    // Stray items with random packet starts
    task automatic send_noise();
        repeat ($urandom_range(6, 1))
            send_item(8'($urandom_range(255, 0)), $urandom_range(3, 0) == 0);
    endtask

    task automatic run_traffic(input int n_items);
        int start;
        start = accepted_count;
        while (accepted_count - start < n_items)
        begin
            if ($urandom_range(99) < 8)
                send_noise();
            else
                send_random_packet();
        end
        // Close on a short packet start so nothing stays held across a register write
        build_packet(3, 1'b1, cur_blocked_pid, 1'b0, 0, 2'b10, random_stamp(), '0, 1'b1);
        send_packet(1'b1);
    endtask

    // Stream begins without a start mark, saturating PTS, then a start mark while byte 1 is held
    task automatic test_stream_start();
        tx_idle_pct = 11;
        rx_idle_pct = 50;
        build_packet(18, 1'b1, 13'h0123, 1'b0, 0, 2'b10, STAMP_MAX, '0, 1'b1);
        send_packet(1'b0);
        send_item(8'h47, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'h47, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h10, 1'b0);
        wait_drained();
    endtask

    task automatic test_mixed_traffic(input int tx_pct, input int rx_pct,
                                      input logic [32:0] offset, input logic block_on,
                                      input logic [12:0] pid);
        set_config(offset, block_on, pid);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        run_traffic(8);
        wait_drained();
    endtask

    // Hold the output off for a long stretch while items keep coming
    task automatic test_output_stall();
        set_config({1'($urandom_range(1, 0)), 32'($urandom())}, 1'b0, 13'h0000);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
        run_traffic(8);
        wait_drained();
    endtask

    // PES header past the packet end with bytes beyond it, and a huge adaptation length
    task automatic test_packet_edges();
        set_config(STAMP_OFFSET_RST, 1'b1, 13'h0000);
        build_packet(190, 1'b1, 13'h0000, 1'b1, 170, 2'b10, random_stamp(), '0, 1'b1);
        send_packet(1'b1);
        build_packet(20, 1'b1, 13'h0000, 1'b1, 255, 2'b11, random_stamp(), random_stamp(), 1'b1);
        send_packet(1'b1);
        wait_drained();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_stream_start();
        test_mixed_traffic(11, 50, 33'h0, 1'b1, 13'h0100);
        test_mixed_traffic(50, 11, STAMP_MAX, 1'b1, NULL_PID);
        test_output_stall();
        test_packet_edges();
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
